// ----- hdl/aled_pkg.sv -----
// ----------------------------------------------------------------------------
// aled_pkg
// Shared types and constants for the addressable LED bit encoder.
// ----------------------------------------------------------------------------
package aled_pkg;

  localparam int BEAD_COUNT    = 64;
  localparam int BEAD_AW       = (BEAD_COUNT > 1) ? $clog2(BEAD_COUNT) : 1;
  localparam int BITS_PER_BEAD = 24;
  localparam int BIT_W         = 5;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [15:0] ZERO_HIGH_RST = 16'd72;
  localparam logic [15:0] ONE_HIGH_RST  = 16'd144;
  localparam logic [9:0]  LATCH_RST     = 10'd224;

  typedef enum logic [1:0] {
    ACT_SET   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_SHOW  = 2'd2,
    ACT_SLOT  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_ZERO_HIGH = 2'd0,
    REG_ONE_HIGH  = 2'd1,
    REG_LATCH     = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] zero_high_ticks;
    logic [15:0] one_high_ticks;
    logic [9:0]  latch_slots;
  } cfg_t;

  typedef struct packed {
    action_t              op;
    logic [BEAD_AW-1:0]   addr;
    logic [23:0]          color;   // green:red:blue
    cfg_t                 cfg;     // settings in force when the command came in
  } cmd_t;

endpackage

// ----- hdl/addressable_led_bit_encoder.sv -----
// ----------------------------------------------------------------------------
// addressable_led_bit_encoder
// GRB pulse-width bit encoder for a chain of addressable LED beads.
// ----------------------------------------------------------------------------
// Commands enter through start/busy into a two-entry queue and are executed
// one at a time by the back end. A slot that finishes a bead then passes
// through the fetch and load states to read the next bead from the frame
// store. A show that starts a frame copies the bead store into the frame
// store one bead per cycle, then drains and loads the first bead. Each slot
// command returns one transaction on duty/frame_end/sending, marked by
// result_valid for a single cycle; the receiver cannot stall it.
// Duty values and latch length are captured when show is accepted.
// ----------------------------------------------------------------------------
module addressable_led_bit_encoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    action,
  input  logic [7:0]                    bead_index,
  input  logic [7:0]                    red,
  input  logic [7:0]                    green,
  input  logic [7:0]                    blue,
  output logic                          result_valid,
  output logic [15:0]                   duty,
  output logic                          frame_end,
  output logic                          sending,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [aled_pkg::APB_AW-1:0]   paddr,
  input  logic [aled_pkg::APB_DW-1:0]   pwdata,
  output logic [aled_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  aled_pkg::cfg_t   cfg;
  aled_pkg::cmd_t   push_cmd;
  aled_pkg::cmd_t   q_data;
  aled_pkg::reg_idx_t reg_sel;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;
  logic             reg_we;

  assign pready  = 1'b1;
  assign reg_we  = psel && penable && pwrite && pready;
  assign reg_sel = aled_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zero_high_ticks <= aled_pkg::ZERO_HIGH_RST;
      cfg.one_high_ticks  <= aled_pkg::ONE_HIGH_RST;
      cfg.latch_slots     <= aled_pkg::LATCH_RST;
    end else if (reg_we) begin
      unique case (reg_sel)
        aled_pkg::REG_ZERO_HIGH: cfg.zero_high_ticks <= pwdata[15:0];
        aled_pkg::REG_ONE_HIGH:  cfg.one_high_ticks  <= pwdata[15:0];
        aled_pkg::REG_LATCH:     cfg.latch_slots     <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      aled_pkg::REG_ZERO_HIGH: prdata = {16'd0, cfg.zero_high_ticks};
      aled_pkg::REG_ONE_HIGH:  prdata = {16'd0, cfg.one_high_ticks};
      aled_pkg::REG_LATCH:     prdata = {22'd0, cfg.latch_slots};
      default:                 prdata = '0;
    endcase
  end

  aled_front u_front (
    .start      (start),
    .action     (action),
    .bead_index (bead_index),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .cfg        (cfg),
    .q_full     (q_full),
    .busy       (busy),
    .push       (push),
    .cmd        (push_cmd)
  );

  aled_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_cmd),
    .pop   (pop),
    .rdata (q_data),
    .full  (q_full),
    .empty (q_empty)
  );

  aled_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (q_data),
    .pop          (pop),
    .result_valid (result_valid),
    .duty         (duty),
    .frame_end    (frame_end),
    .sending      (sending)
  );

endmodule

// ----- hdl/aled_front.sv -----
// ----------------------------------------------------------------------------
// aled_front
// Takes commands, drops out-of-range bead writes and builds queue entries.
// ----------------------------------------------------------------------------
module aled_front (
  input  logic                 start,
  input  logic [1:0]           action,
  input  logic [7:0]           bead_index,
  input  logic [7:0]           red,
  input  logic [7:0]           green,
  input  logic [7:0]           blue,
  input  aled_pkg::cfg_t       cfg,
  input  logic                 q_full,
  output logic                 busy,
  output logic                 push,
  output aled_pkg::cmd_t       cmd
);

  logic in_range;
  logic is_set;

  assign in_range = (bead_index < 8'(aled_pkg::BEAD_COUNT));
  assign is_set   = (aled_pkg::action_t'(action) == aled_pkg::ACT_SET);

  assign busy = q_full;
  // a set to a bead past the chain is taken but never queued
  assign push = start && !q_full && (!is_set || in_range);

  always_comb begin
    cmd.op    = aled_pkg::action_t'(action);
    cmd.addr  = bead_index[aled_pkg::BEAD_AW-1:0];
    cmd.color = {green, red, blue};
    cmd.cfg   = cfg;
  end

endmodule

// ----- hdl/aled_queue.sv -----
// ----------------------------------------------------------------------------
// aled_queue
// Short command FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module aled_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  aled_pkg::cmd_t       wdata,
  input  logic                 pop,
  output aled_pkg::cmd_t       rdata,
  output logic                 full,
  output logic                 empty
);

  aled_pkg::cmd_t                 entries [aled_pkg::QUEUE_DEPTH];
  logic [aled_pkg::QPTR_W-1:0]    wr_ptr;
  logic [aled_pkg::QPTR_W-1:0]    rd_ptr;
  logic [aled_pkg::QCNT_W-1:0]    count;

  function automatic logic [aled_pkg::QPTR_W-1:0] ptr_inc(
    input logic [aled_pkg::QPTR_W-1:0] p
  );
    if (p == aled_pkg::QPTR_W'(aled_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign full  = (count == aled_pkg::QCNT_W'(aled_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/aled_back.sv -----
// ----------------------------------------------------------------------------
// aled_back
// Executes queued commands: bead store, frame snapshot and slot encoding.
// ----------------------------------------------------------------------------
module aled_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  aled_pkg::cmd_t       q_data,
  output logic                 pop,
  output logic                 result_valid,
  output logic [15:0]          duty,
  output logic                 frame_end,
  output logic                 sending
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_COPY  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_FETCH = 5'b01000,
    ST_LOAD  = 5'b10000
  } state_t;

  localparam logic [aled_pkg::BEAD_AW-1:0] LAST_BEAD =
    aled_pkg::BEAD_AW'(aled_pkg::BEAD_COUNT - 1);
  localparam logic [aled_pkg::BIT_W-1:0] LAST_BIT =
    aled_pkg::BIT_W'(aled_pkg::BITS_PER_BEAD - 1);

  state_t                        state;
  logic                          frame_busy;
  logic                          in_tail;
  logic [aled_pkg::BEAD_AW-1:0]  bead;
  logic [aled_pkg::BIT_W-1:0]    bit_idx;
  logic [9:0]                    tail_left;
  logic [23:0]                   sreg;
  aled_pkg::cfg_t                fcfg;
  logic [aled_pkg::BEAD_AW-1:0]  cp;
  logic [aled_pkg::BEAD_COUNT-1:0] pix_valid;
  logic                          wr_pend;
  logic [aled_pkg::BEAD_AW-1:0]  wr_addr;
  logic [23:0]                   pix_rd;
  logic                          pix_rd_vld;
  logic [23:0]                   frame_rd;

  logic [23:0] pixel_mem [aled_pkg::BEAD_COUNT];
  logic [23:0] frame_mem [aled_pkg::BEAD_COUNT];

  logic pix_we;

  assign pop    = (state == ST_IDLE) && !q_empty;
  assign pix_we = pop && (q_data.op == aled_pkg::ACT_SET);

  // bead store; never-written or cleared entries are masked by pix_valid
  always_ff @(posedge clk) begin
    if (pix_we) begin
      pixel_mem[q_data.addr] <= q_data.color;
    end
    pix_rd     <= pixel_mem[cp];
    pix_rd_vld <= pix_valid[cp];
    wr_addr    <= cp;
  end

  always_ff @(posedge clk) begin
    if (wr_pend) begin
      frame_mem[wr_addr] <= pix_rd_vld ? pix_rd : 24'd0;
    end
    frame_rd <= frame_mem[bead];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      frame_busy   <= 1'b0;
      in_tail      <= 1'b0;
      bead         <= '0;
      bit_idx      <= '0;
      tail_left    <= '0;
      cp           <= '0;
      pix_valid    <= '0;
      wr_pend      <= 1'b0;
      result_valid <= 1'b0;
      duty         <= '0;
      frame_end    <= 1'b0;
      sending      <= 1'b0;
      fcfg         <= '{aled_pkg::ZERO_HIGH_RST, aled_pkg::ONE_HIGH_RST,
                        aled_pkg::LATCH_RST};
    end else begin
      result_valid <= 1'b0;
      wr_pend      <= (state == ST_COPY);
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            unique case (q_data.op)
              aled_pkg::ACT_SET: begin
                pix_valid[q_data.addr] <= 1'b1;
              end
              aled_pkg::ACT_CLEAR: begin
                pix_valid <= '0;
              end
              aled_pkg::ACT_SHOW: begin
                if (!frame_busy) begin
                  fcfg       <= q_data.cfg;
                  frame_busy <= 1'b1;
                  in_tail    <= 1'b0;
                  bead       <= '0;
                  bit_idx    <= '0;
                  cp         <= '0;
                  state      <= ST_COPY;
                end
              end
              aled_pkg::ACT_SLOT: begin
                result_valid <= 1'b1;
                frame_end    <= 1'b0;
                if (!frame_busy) begin
                  duty    <= '0;
                  sending <= 1'b0;
                end else if (!in_tail) begin
                  sending <= 1'b1;
                  duty    <= sreg[23] ? fcfg.one_high_ticks : fcfg.zero_high_ticks;
                  sreg    <= {sreg[22:0], 1'b0};
                  if (bit_idx == LAST_BIT) begin
                    bit_idx <= '0;
                    if (bead == LAST_BEAD) begin
                      if (fcfg.latch_slots == '0) begin
                        frame_end  <= 1'b1;
                        frame_busy <= 1'b0;
                      end else begin
                        in_tail   <= 1'b1;
                        tail_left <= fcfg.latch_slots;
                      end
                    end else begin
                      bead  <= bead + 1'b1;
                      state <= ST_FETCH;
                    end
                  end else begin
                    bit_idx <= bit_idx + 1'b1;
                  end
                end else begin
                  sending   <= 1'b1;
                  duty      <= '0;
                  tail_left <= tail_left - 1'b1;
                  if (tail_left == 10'd1) begin
                    frame_end  <= 1'b1;
                    frame_busy <= 1'b0;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_COPY: begin
          if (cp == LAST_BEAD) begin
            state <= ST_DRAIN;
          end else begin
            cp <= cp + 1'b1;
          end
        end
        ST_DRAIN: state <= ST_FETCH;
        ST_FETCH: state <= ST_LOAD;
        ST_LOAD: begin
          sreg  <= frame_rd;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/addressable_led_bit_encoder_tb.sv -----
// ----------------------------------------------------------------------------
// addressable_led_bit_encoder_tb
// Self-checking bench for the GRB pulse-width bit encoder.
// ----------------------------------------------------------------------------
// A directed table covers reset state, store extremes, ignored sets and
// shows, and set/clear during a frame. Several random phases follow, each
// with its own register setting. A frame is longer than the whole run, so the
// frame started in the directed part stays in progress and the phases check
// that new settings and store updates leave it untouched.
// Slot transactions come from a local model of the bead and frame stores or
// from typed table rows, and are checked field by field on result_valid.
// ----------------------------------------------------------------------------
module addressable_led_bit_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aled_pkg::*;

  localparam int DATA_SLOTS   = BEAD_COUNT * BITS_PER_BEAD;
  localparam int RAND_ITEMS   = 1150;
  localparam int QUIET_CYCLES = 4 * BEAD_COUNT;
  localparam int DRAIN_LIMIT  = 10000;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int UNMAPPED_REG = 3;
  localparam int N_DIRECTED   = 21;

  typedef struct packed {
    logic [15:0] duty;
    logic        frame_end;
    logic        sending;
  } slot_result_t;

  typedef struct packed {
    action_t      act;
    logic [7:0]   idx;
    logic [7:0]   red;
    logic [7:0]   green;
    logic [7:0]   blue;
    logic         typed;
    slot_result_t res;
  } stim_row_t;

  localparam slot_result_t NO_RES = '0;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          action = ACT_SET;
  logic [7:0]          bead_index = '0;
  logic [7:0]          red = '0;
  logic [7:0]          green = '0;
  logic [7:0]          blue = '0;
  logic                result_valid;
  logic [15:0]         duty;
  logic                frame_end;
  logic                sending;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  addressable_led_bit_encoder dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .bead_index(bead_index), .red(red), .green(green),
    .blue(blue), .result_valid(result_valid), .duty(duty),
    .frame_end(frame_end), .sending(sending), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Local copy of the encoder state
  logic [23:0]  bead_colors [BEAD_COUNT];
  logic [23:0]  frame_colors [BEAD_COUNT];
  cfg_t         live_cfg;
  logic [15:0]  frame_zero;
  logic [15:0]  frame_one;
  int           frame_slots;
  int           slot_idx;
  bit           frame_on;

  slot_result_t expected_slots [$];
  int           mismatches = 0;
  int           cycles = 0;
  bit           idle_on = 1'b1;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{ACT_SLOT,  8'd0,   8'h00, 8'h00, 8'h00, 1'b1, '{16'd0, 1'b0, 1'b0}},
    '{ACT_SET,   8'd0,   8'h00, 8'hFF, 8'h00, 1'b0, NO_RES},
    '{ACT_SET,   8'd63,  8'hFF, 8'hFF, 8'hFF, 1'b0, NO_RES},
    '{ACT_SET,   8'd64,  8'hFF, 8'hFF, 8'hFF, 1'b0, NO_RES},
    '{ACT_SET,   8'd255, 8'hFF, 8'hFF, 8'hFF, 1'b0, NO_RES},
    '{ACT_SET,   8'd1,   8'hA5, 8'h5A, 8'h81, 1'b0, NO_RES},
    '{ACT_SHOW,  8'd0,   8'h00, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ACT_SET,   8'd0,   8'h00, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ACT_SHOW,  8'd0,   8'h00, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ACT_SLOT,  8'd0,   8'h00, 8'h00, 8'h00, 1'b1, '{16'd144, 1'b0, 1'b1}},
    '{ACT_SLOT,  8'd255, 8'hFF, 8'hFF, 8'hFF, 1'b0, NO_RES},
    '{ACT_SLOT,  8'd0,   8'h00, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ACT_SLOT,  8'd0,   8'h00, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ACT_SLOT,  8'd0,   8'h00, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ACT_SLOT,  8'd0,   8'h00, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ACT_SLOT,  8'd0,   8'h00, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ACT_CLEAR, 8'd0,   8'h00, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ACT_SLOT,  8'd0,   8'h00, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ACT_SLOT,  8'd0,   8'h00, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ACT_SLOT,  8'd0,   8'h00, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ACT_SHOW,  8'd0,   8'h00, 8'h00, 8'h00, 1'b0, NO_RES}
  };

  // Applies one command to the local state; returns 1 when a slot
  // transaction is due, with its expected fields in res.
  function automatic bit encode_command(input action_t act, input logic [7:0] idx,
                                        input logic [23:0] grb, output slot_result_t res);
    int bead;
    int bitpos;
    res = '0;
    encode_command = 1'b0;
    case (act)
      ACT_SET: begin
        if (idx < BEAD_COUNT) bead_colors[idx] = grb;
      end
      ACT_CLEAR: begin
        foreach (bead_colors[i]) bead_colors[i] = '0;
      end
      ACT_SHOW: begin
        if (!frame_on) begin
          frame_colors = bead_colors;
          frame_zero   = live_cfg.zero_high_ticks;
          frame_one    = live_cfg.one_high_ticks;
          frame_slots  = DATA_SLOTS + live_cfg.latch_slots;
          slot_idx     = 0;
          frame_on     = 1'b1;
        end
      end
      default: begin
        encode_command = 1'b1;
        if (frame_on) begin
          if (slot_idx < DATA_SLOTS) begin
            bead   = slot_idx / BITS_PER_BEAD;
            bitpos = slot_idx % BITS_PER_BEAD;
            // green msb sits at bit 23, blue lsb at bit 0
            res.duty = frame_colors[bead][23 - bitpos] ? frame_one : frame_zero;
          end
          slot_idx++;
          res.sending = 1'b1;
          if (slot_idx >= frame_slots) begin
            res.frame_end = 1'b1;
            frame_on      = 1'b0;
            slot_idx      = 0;
          end
        end
      end
    endcase
  endfunction

  task automatic issue(input action_t act, input logic [7:0] idx, input logic [7:0] r,
                       input logic [7:0] g, input logic [7:0] b, input bit typed,
                       input slot_result_t typed_res);
    slot_result_t res;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    start      <= 1'b1;
    action     <= act;
    bead_index <= idx;
    red        <= r;
    green      <= g;
    blue       <= b;
    do @(posedge clk); while (busy);
    if (encode_command(act, idx, {g, r, b}, res))
      expected_slots.push_back(typed ? typed_res : res);
  endtask

  task automatic issue_rand(input action_t act);
    logic [7:0] idx;
    if ($urandom_range(0, 4) == 0) idx = 8'($urandom_range(0, 255));
    else idx = 8'($urandom_range(0, BEAD_COUNT - 1));
    issue(act, idx, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, NO_RES);
  endtask

  // Hold off until all slot transactions are back, then let the back end
  // finish any store walk still in flight.
  task automatic settle(input int extra);
    start <= 1'b0;
    while (expected_slots.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic apb_write(input int idx, input logic [31:0] data);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(idx * 4);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ZERO_HIGH: live_cfg.zero_high_ticks = data[15:0];
      REG_ONE_HIGH:  live_cfg.one_high_ticks  = data[15:0];
      REG_LATCH:     live_cfg.latch_slots     = data[9:0];
      default: ;
    endcase
    if (idx == UNMAPPED_REG) begin
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end else begin
      // read back
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      case (idx)
        REG_ZERO_HIGH: want = {16'd0, live_cfg.zero_high_ticks};
        REG_ONE_HIGH:  want = {16'd0, live_cfg.one_high_ticks};
        default:       want = {22'd0, live_cfg.latch_slots};
      endcase
      if (prdata !== want) begin
        $display("%0t: reg %0d readback expected %h actual %h", $time, idx, want, prdata);
        mismatches++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
    end
    @(posedge clk);
  endtask

  // Upper pwdata bits are random and must be dropped by the register
  task automatic write_cfg(input logic [15:0] zero_t, input logic [15:0] one_t,
                           input logic [9:0] latch);
    logic [31:0] junk;
    junk = $urandom;
    apb_write(REG_ZERO_HIGH, {junk[31:16], zero_t});
    junk = $urandom;
    apb_write(REG_ONE_HIGH, {junk[31:16], one_t});
    junk = $urandom;
    apb_write(REG_LATCH, {junk[31:10], latch});
    apb_write(UNMAPPED_REG, $urandom);
  endtask

  always @(posedge clk) begin : check_results
    slot_result_t want;
    if (!rst && result_valid) begin
      if (expected_slots.size() == 0) begin
        $display("%0t: unexpected transaction duty %0d frame_end %0b sending %0b",
                 $time, duty, frame_end, sending);
        mismatches++;
      end else begin
        want = expected_slots.pop_front();
        if (duty !== want.duty) begin
          $display("%0t: duty expected %0d actual %0d", $time, want.duty, duty);
          mismatches++;
        end
        if (frame_end !== want.frame_end) begin
          $display("%0t: frame_end expected %0b actual %0b", $time, want.frame_end,
                   frame_end);
          mismatches++;
        end
        if (sending !== want.sending) begin
          $display("%0t: sending expected %0b actual %0b", $time, want.sending, sending);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("addressable_led_bit_encoder verification failed");
      $finish;
    end
  end

  initial begin
    int      pick;
    int      rand_count;
    int      drain;
    action_t act_pick;

    foreach (bead_colors[i]) bead_colors[i] = '0;
    foreach (frame_colors[i]) frame_colors[i] = '0;
    live_cfg    = '{ZERO_HIGH_RST, ONE_HIGH_RST, LATCH_RST};
    frame_zero  = ZERO_HIGH_RST;
    frame_one   = ONE_HIGH_RST;
    frame_slots = 0;
    slot_idx    = 0;
    frame_on    = 1'b0;
    rand_count  = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      issue(directed_rows[i].act, directed_rows[i].idx, directed_rows[i].red,
            directed_rows[i].green, directed_rows[i].blue, directed_rows[i].typed,
            directed_rows[i].res);

    // new settings mid-frame must only apply from the next show
    settle(QUIET_CYCLES);
    write_cfg(16'd5, 16'd9, 10'd3);

    for (int ph = 0; ph < 4; ph++) begin
      settle(QUIET_CYCLES);
      case (ph)
        0: write_cfg(16'h0000, 16'hFFFF, 10'd0);
        1: write_cfg(16'hFFFF, 16'h0000, 10'd1023);
        2: write_cfg(16'($urandom), 16'($urandom), 10'($urandom_range(1, 63)));
        default: write_cfg(ZERO_HIGH_RST, ONE_HIGH_RST, LATCH_RST);
      endcase
      idle_on = (ph != 3);
      while (rand_count < (ph + 1) * RAND_ITEMS / 4) begin
        pick = $urandom_range(0, 99);
        if (!frame_on) begin
          if (pick < 55)      act_pick = ACT_SET;
          else if (pick < 60) act_pick = ACT_CLEAR;
          else if (pick < 70) act_pick = ACT_SLOT;
          else                act_pick = ACT_SHOW;
        end else begin
          if (pick < 90)      act_pick = ACT_SLOT;
          else if (pick < 95) act_pick = ACT_SET;
          else if (pick < 97) act_pick = ACT_CLEAR;
          else                act_pick = ACT_SHOW;
        end
        issue_rand(act_pick);
        rand_count++;
        if (idle_on && $urandom_range(0, 299) == 0) settle(1);
      end
    end

    start <= 1'b0;
    drain = 0;
    while (expected_slots.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (QUIET_CYCLES) @(posedge clk);
    if (expected_slots.size() != 0) begin
      $display("%0t: %0d expected slot transactions never arrived", $time,
               expected_slots.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("addressable_led_bit_encoder verification clean");
    end else begin
      $display("addressable_led_bit_encoder verification failed");
    end
    $finish;
  end

endmodule
